// File: rtl/motor_feedback_turn_tracker_top_defines.svh
// Assertion macros shared by the turn tracker RTL.
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MFTT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mftt assertion failed");

// Next-cycle implication.
`define MFTT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mftt assertion failed");

`endif

// File: rtl/mftt_pkg.sv
// Types and constants for the motor feedback turn tracker.
package mftt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS0_BASE_ID   = 3'd0,
    CFG_BUS0_FIRST     = 3'd1,
    CFG_BUS0_COUNT     = 3'd2,
    CFG_BUS1_BASE_ID   = 3'd3,
    CFG_BUS1_FIRST     = 3'd4,
    CFG_BUS1_COUNT     = 3'd5,
    CFG_TURN_ENABLE    = 3'd6,
    CFG_WRAP_THRESHOLD = 3'd7
  } cfg_reg_e;

  localparam logic [10:0] RST_BUS0_BASE_ID   = 11'd513;
  localparam logic [2:0]  RST_BUS0_FIRST     = 3'd4;
  localparam logic [3:0]  RST_BUS0_COUNT     = 4'd4;
  localparam logic [10:0] RST_BUS1_BASE_ID   = 11'd513;
  localparam logic [2:0]  RST_BUS1_FIRST     = 3'd0;
  localparam logic [3:0]  RST_BUS1_COUNT     = 4'd5;
  localparam logic [7:0]  RST_TURN_ENABLE    = 8'd31;
  localparam logic [15:0] RST_WRAP_THRESHOLD = 16'd5000;

  // A bus never maps more identifiers than this.
  localparam logic [3:0]  MAX_ID_COUNT = 4'd8;

  localparam logic signed [31:0] TURNS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] TURNS_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic        bus_sel;
    logic [10:0] frame_id;
    logic [63:0] payload;
    logic        clear_turns;
  } frame_in_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         slot;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic [15:0]        current;
    logic [7:0]         temperature;
    logic signed [31:0] turns;
  } frame_out_t;

endpackage

// File: rtl/motor_feedback_turn_tracker_top.sv
// Motor feedback turn tracker: maps a CAN feedback frame to a motor slot and
// keeps a per-slot multi-turn count from encoder wraps. Timing: one frame per
// clock is sustained while the output is not stalled; each passes the update
// stage, then the output register. Per-slot last angle and turn count live in
// two memories with a registered read, issued when a frame is taken; the
// write-back happens as the frame leaves the update stage, with a forwarding
// register covering back-to-back frames to the same slot. Reset and the clear
// flag act through per-slot valid bits, so no clearing pass exists. The user
// writes configuration through cfg_* while no frame is in flight (not enforced).
`include "motor_feedback_turn_tracker_top_defines.svh"

module motor_feedback_turn_tracker_top
  import mftt_pkg::*;
#(
  parameter int MOTOR_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // frame input transaction
  input  logic                  in_valid,
  output logic                  in_stall,
  input  frame_in_t             in_data,
  // result transaction
  output logic                  out_valid,
  input  logic                  out_stall,
  output frame_out_t            out_data,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_AW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] bus0_base_id, bus1_base_id;
  logic [2:0]  bus0_first_slot, bus1_first_slot;
  logic [3:0]  bus0_id_count, bus1_id_count;
  logic [7:0]  turn_count_enable;
  logic [15:0] wrap_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus0_base_id      <= RST_BUS0_BASE_ID;
      bus0_first_slot   <= RST_BUS0_FIRST;
      bus0_id_count     <= RST_BUS0_COUNT;
      bus1_base_id      <= RST_BUS1_BASE_ID;
      bus1_first_slot   <= RST_BUS1_FIRST;
      bus1_id_count     <= RST_BUS1_COUNT;
      turn_count_enable <= RST_TURN_ENABLE;
      wrap_threshold    <= RST_WRAP_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_BUS0_BASE_ID:   bus0_base_id      <= cfg_data[10:0];
        CFG_BUS0_FIRST:     bus0_first_slot   <= cfg_data[2:0];
        CFG_BUS0_COUNT:     bus0_id_count     <= cfg_data[3:0];
        CFG_BUS1_BASE_ID:   bus1_base_id      <= cfg_data[10:0];
        CFG_BUS1_FIRST:     bus1_first_slot   <= cfg_data[2:0];
        CFG_BUS1_COUNT:     bus1_id_count     <= cfg_data[3:0];
        CFG_TURN_ENABLE:    turn_count_enable <= cfg_data[7:0];
        CFG_WRAP_THRESHOLD: wrap_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: identifier to slot mapping, memory read issue
  // ---------------------------------------------------------------------------
  logic [10:0]        map_base;
  logic [2:0]         map_first;
  logic [3:0]         map_count;
  logic [3:0]         map_count_eff;
  logic signed [11:0] map_offset;
  logic [2:0]         in_slot;
  logic               in_acc;
  logic [SLOT_AW-1:0] in_idx;
  logic               in_take;

  always_comb begin
    map_base   = in_data.bus_sel ? bus1_base_id    : bus0_base_id;
    map_first  = in_data.bus_sel ? bus1_first_slot : bus0_first_slot;
    map_count  = in_data.bus_sel ? bus1_id_count   : bus0_id_count;
    map_count_eff = (map_count > MAX_ID_COUNT) ? MAX_ID_COUNT : map_count;
    map_offset = $signed({1'b0, in_data.frame_id}) - $signed({1'b0, map_base});
    in_slot    = map_first + map_offset[2:0];
    in_acc     = !map_offset[11] && (map_offset[10:0] < {7'd0, map_count_eff})
                 && (int'(in_slot) < MOTOR_SLOTS);
    in_idx     = SLOT_AW'(in_slot);
  end

  // ---------------------------------------------------------------------------
  // Update stage registers
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  logic               s1_acc;
  logic               s1_clr;
  logic [2:0]         s1_slot;
  logic [SLOT_AW-1:0] s1_idx;
  logic [63:0]        s1_payload;
  logic               s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_acc     <= in_acc;
      s1_clr     <= in_data.clear_turns;
      s1_slot    <= in_slot;
      s1_idx     <= in_idx;
      s1_payload <= in_data.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // State memories, valid bits and forwarding
  // ---------------------------------------------------------------------------
  logic [15:0]        angle_mem [MOTOR_SLOTS];
  logic signed [31:0] turn_mem  [MOTOR_SLOTS];
  logic [15:0]        rd_angle;
  logic signed [31:0] rd_turn;
  logic [MOTOR_SLOTS-1:0] angle_vld, turn_vld;
  logic [MOTOR_SLOTS-1:0] angle_vld_next, turn_vld_next;

  // Last write-back, replayed when the next frame read the same slot in the
  // very cycle that slot was written.
  logic               fwd_hit;
  logic [15:0]        fwd_angle;
  logic signed [31:0] fwd_turn;

  logic               s1_write;
  logic [15:0]        new_angle;
  logic signed [31:0] new_turn;

  assign s1_write = s1_adv && s1_acc;

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_angle <= angle_mem[in_idx];
      rd_turn  <= turn_mem[in_idx];
    end
    if (s1_write) begin
      angle_mem[s1_idx] <= new_angle;
      turn_mem[s1_idx]  <= new_turn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_take) begin
      fwd_hit <= s1_write && in_acc && (s1_idx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_angle <= new_angle;
      fwd_turn  <= new_turn;
    end
  end

  always_comb begin
    angle_vld_next = angle_vld;
    turn_vld_next  = turn_vld;
    if (s1_adv && s1_clr) begin
      turn_vld_next = '0;
    end
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      if (s1_write && (int'(s1_idx) == i)) begin
        angle_vld_next[i] = 1'b1;
        turn_vld_next[i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_vld <= '0;
      turn_vld  <= '0;
    end else begin
      angle_vld <= angle_vld_next;
      turn_vld  <= turn_vld_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Update: wrap detection and saturating turn count
  // ---------------------------------------------------------------------------
  logic [15:0]        old_angle;
  logic signed [31:0] old_turn;
  logic signed [16:0] delta;
  logic signed [17:0] thr_pos, thr_neg;
  logic               slot_en;

  always_comb begin
    old_angle = fwd_hit ? fwd_angle : (angle_vld[s1_idx] ? rd_angle : 16'd0);
    if (s1_clr) begin
      old_turn = '0;
    end else if (fwd_hit) begin
      old_turn = fwd_turn;
    end else begin
      old_turn = turn_vld[s1_idx] ? rd_turn : 32'sd0;
    end
    new_angle = s1_payload[63:48];
    delta     = $signed({1'b0, new_angle}) - $signed({1'b0, old_angle});
    thr_pos   = $signed({2'b00, wrap_threshold});
    thr_neg   = -thr_pos;
    slot_en   = turn_count_enable[s1_slot];
    new_turn  = old_turn;
    if (slot_en) begin
      priority if (18'(delta) > thr_pos) begin
        if (old_turn != TURNS_MIN) new_turn = old_turn - 32'sd1;
      end else if (18'(delta) < thr_neg) begin
        if (old_turn != TURNS_MAX) new_turn = old_turn + 32'sd1;
      end else begin
        new_turn = old_turn;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  frame_out_t out_next;

  always_comb begin
    out_next = '0;
    if (s1_acc) begin
      out_next.accepted    = 1'b1;
      out_next.slot        = s1_slot;
      out_next.angle       = new_angle;
      out_next.speed       = $signed(s1_payload[47:32]);
      out_next.current     = s1_payload[31:16];
      out_next.temperature = s1_payload[15:8];
      out_next.turns       = new_turn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= out_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MFTT_ASSERT_NOW(a_stall_only_busy, in_stall, s1_valid)
  `MFTT_ASSERT_NOW(a_reject_zero, out_valid && !out_data.accepted,
                   out_data.turns == 32'sd0 && out_data.angle == 16'd0)
  `MFTT_ASSERT_NOW(a_slot_in_range, out_valid && out_data.accepted,
                   int'(out_data.slot) < MOTOR_SLOTS)
  `MFTT_ASSERT_NEXT(a_clear_leaves_one, s1_adv && s1_clr, $onehot0(turn_vld))

endmodule

// File: dv/motor_feedback_turn_tracker_top_tb.sv
// Self-checking testbench for the motor feedback turn tracker.
`timescale 1ns / 1ps

module motor_feedback_turn_tracker_top_tb;
  import mftt_pkg::*;

  localparam int SLOTS          = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_FRAMES  = 190;   // per phase, eight phases
  localparam frame_out_t MISS   = '0;    // rejected frame: every field zero

  // One row of the directed table: a frame, and where the answer is obvious,
  // the result typed in by hand. Rows without one go through the predictor.
  typedef struct packed {
    frame_in_t  frame;
    logic       typed;
    frame_out_t want;
  } feedback_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  frame_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  frame_out_t            out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #5 clk = ~clk;

  motor_feedback_turn_tracker_top #(.MOTOR_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the tracker: register file plus per-slot angle and turns.
  // ---------------------------------------------------------------------------
  logic [10:0]        base_id    [2] = '{RST_BUS0_BASE_ID, RST_BUS1_BASE_ID};
  logic [2:0]         first_slot [2] = '{RST_BUS0_FIRST, RST_BUS1_FIRST};
  logic [3:0]         id_count   [2] = '{RST_BUS0_COUNT, RST_BUS1_COUNT};
  logic [7:0]         turn_enable    = RST_TURN_ENABLE;
  logic [15:0]        wrap_thr       = RST_WRAP_THRESHOLD;
  logic [15:0]        slot_angle [SLOTS] = '{default: '0};
  logic signed [31:0] slot_turns [SLOTS] = '{default: '0};

  frame_out_t    pending_results [$];   // oldest expected result first
  feedback_row_t feedback_rows [$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  int            send_pct     = 0;      // chance per cycle that the sender idles
  int            recv_pct     = 0;      // chance per cycle that the sink stalls

  // Maps a frame to its slot, advances that slot's wrap count and returns the
  // result the block should produce. The clear acts before the mapping.
  function automatic frame_out_t track_frame(frame_in_t f);
    frame_out_t         r;
    int                 span;
    int                 offset;
    int                 delta;
    int                 thr;
    logic [2:0]         s;
    logic [15:0]        ang;
    logic signed [31:0] t;
    r = '0;
    if (f.clear_turns) begin
      for (int k = 0; k < SLOTS; k++) slot_turns[k] = '0;
    end
    span   = (id_count[f.bus_sel] > MAX_ID_COUNT) ? int'(MAX_ID_COUNT)
                                                  : int'(id_count[f.bus_sel]);
    offset = int'(f.frame_id) - int'(base_id[f.bus_sel]);
    if (offset < 0 || offset >= span) return r;
    s = first_slot[f.bus_sel] + offset[2:0];
    if (int'(s) >= SLOTS) return r;

    ang   = f.payload[63:48];
    delta = int'(ang) - int'(slot_angle[s]);
    slot_angle[s] = ang;
    thr = int'(wrap_thr);
    t   = slot_turns[s];
    if (turn_enable[s]) begin
      // forward jump past the threshold means the encoder wrapped backward
      if (delta > thr) begin
        if (t != TURNS_MIN) t = t - 1;
      end else if (delta < -thr) begin
        if (t != TURNS_MAX) t = t + 1;
      end
      slot_turns[s] = t;
    end
    r.accepted    = 1'b1;
    r.slot        = s;
    r.angle       = ang;
    r.speed       = f.payload[47:32];
    r.current     = f.payload[31:16];
    r.temperature = f.payload[15:8];
    r.turns       = t;
    return r;
  endfunction

  function automatic frame_in_t frm(logic bus, logic [10:0] id, logic [63:0] pl,
                                    logic clr);
    frame_in_t f;
    f.bus_sel     = bus;
    f.frame_id    = id;
    f.payload     = pl;
    f.clear_turns = clr;
    return f;
  endfunction

  function automatic frame_out_t hit(logic [2:0] s, logic [15:0] ang,
                                     logic [15:0] spd, logic [15:0] cur,
                                     logic [7:0] temp, logic signed [31:0] turns);
    frame_out_t r;
    r.accepted    = 1'b1;
    r.slot        = s;
    r.angle       = ang;
    r.speed       = spd;
    r.current     = cur;
    r.temperature = temp;
    r.turns       = turns;
    return r;
  endfunction

  // Mostly frames that land in a mapped slot, with angles placed right at the
  // wrap threshold, just past it, or close to the last one. The rest are
  // random identifiers and identifiers just outside the mapped window.
  function automatic frame_in_t random_frame();
    frame_in_t   f;
    int          span;
    logic [10:0] off;
    logic [2:0]  s;
    logic [15:0] prev;
    f.bus_sel     = 1'($urandom_range(1));
    f.frame_id    = 11'($urandom);
    f.payload     = {$urandom, $urandom};
    f.clear_turns = ($urandom_range(99) < 3);
    span = (id_count[f.bus_sel] > MAX_ID_COUNT) ? int'(MAX_ID_COUNT)
                                                : int'(id_count[f.bus_sel]);
    if (span != 0 && $urandom_range(99) < 85) begin
      off        = 11'($urandom_range(span - 1));
      f.frame_id = base_id[f.bus_sel] + off;
      s    = first_slot[f.bus_sel] + off[2:0];
      prev = slot_angle[s];
      case ($urandom_range(3))
        0:       f.payload[63:48] = prev + wrap_thr + 16'($urandom_range(1));
        1:       f.payload[63:48] = prev - wrap_thr - 16'($urandom_range(1));
        2:       f.payload[63:48] = prev + 16'($urandom_range(200)) - 16'd100;
        default: ;
      endcase
    end else if ($urandom_range(1) == 1) begin
      f.frame_id = $urandom_range(1) ? base_id[f.bus_sel] - 11'd1
                                     : base_id[f.bus_sel] + 11'(span);
    end
    return f;
  endfunction

  // One register write; the shadow copy changes at the handshake. cfg_valid
  // stays up so back-to-back writes follow without a gap.
  task automatic cfg_write(cfg_reg_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUS0_BASE_ID:   base_id[0]    = val[10:0];
      CFG_BUS0_FIRST:     first_slot[0] = val[2:0];
      CFG_BUS0_COUNT:     id_count[0]   = val[3:0];
      CFG_BUS1_BASE_ID:   base_id[1]    = val[10:0];
      CFG_BUS1_FIRST:     first_slot[1] = val[2:0];
      CFG_BUS1_COUNT:     id_count[1]   = val[3:0];
      CFG_TURN_ENABLE:    turn_enable   = val[7:0];
      CFG_WRAP_THRESHOLD: wrap_thr      = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] b0, logic [15:0] f0, logic [15:0] c0,
                              logic [15:0] b1, logic [15:0] f1, logic [15:0] c1,
                              logic [15:0] en, logic [15:0] thr);
    cfg_write(CFG_BUS0_BASE_ID, b0);
    cfg_write(CFG_BUS0_FIRST, f0);
    cfg_write(CFG_BUS0_COUNT, c0);
    cfg_write(CFG_BUS1_BASE_ID, b1);
    cfg_write(CFG_BUS1_FIRST, f1);
    cfg_write(CFG_BUS1_COUNT, c1);
    cfg_write(CFG_TURN_ENABLE, en);
    cfg_write(CFG_WRAP_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // Offers one frame and waits for the transaction. in_valid is left high so
  // the next frame can follow in the very next cycle.
  task automatic send_frame(frame_in_t f, logic typed, frame_out_t want);
    frame_out_t predicted;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    predicted = track_frame(f);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stall, and the scoreboard compare at each transaction.
  // Outputs are read at the edge, before the block's registers move.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: result with nothing pending, slot %0d turns %0d",
                   out_data.slot, out_data.turns);
      end else begin
        want = pending_results.pop_front();
        if (out_data.accepted    !== want.accepted  ||
            out_data.slot        !== want.slot      ||
            out_data.angle       !== want.angle     ||
            out_data.speed       !== want.speed     ||
            out_data.current     !== want.current   ||
            out_data.temperature !== want.temperature ||
            out_data.turns       !== want.turns) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"error: exp acc %0d slot %0d ang %0d spd %0d cur %0d ",
                      "temp %0d turns %0d, got acc %0d slot %0d ang %0d ",
                      "spd %0d cur %0d temp %0d turns %0d"},
                     want.accepted, want.slot, want.angle, want.speed,
                     want.current, want.temperature, want.turns,
                     out_data.accepted, out_data.slot, out_data.angle,
                     out_data.speed, out_data.current, out_data.temperature,
                     out_data.turns);
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: eight phases, each with a register setting and one of four idling
  // mode. Phase zero runs at reset values and starts with the directed table.
  // ---------------------------------------------------------------------------
  initial begin
    // Reset values: bus 0 ids 513..516 -> slots 4..7, bus 1 ids 513..517 ->
    // slots 0..4, counting on slots 0..4, threshold 5000.
    // Payload layout: angle, speed, current, temperature, spare byte.
    feedback_rows.push_back('{frm(1'b0, 11'd512, 64'h1234_5678_9ABC_DE01, 1'b0),
                              1'b1, MISS});                       // below window
    feedback_rows.push_back('{frm(1'b0, 11'd517, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0),
                              1'b1, MISS});                       // one past window
    feedback_rows.push_back('{frm(1'b0, 11'd513, 64'h0000_8000_FFFF_FFAA, 1'b0),
                              1'b1, hit(3'd4, 16'h0000, 16'h8000, 16'hFFFF, 8'hFF, 0)});
    // full-scale forward jump: one turn down
    feedback_rows.push_back('{frm(1'b0, 11'd513, 64'hFFFF_7FFF_0000_0055, 1'b0),
                              1'b1, hit(3'd4, 16'hFFFF, 16'h7FFF, 16'h0000, 8'h00, -1)});
    // and back again
    feedback_rows.push_back('{frm(1'b0, 11'd513, 64'h0000_0000_0000_0000, 1'b0),
                              1'b1, hit(3'd4, 16'h0000, 16'h0000, 16'h0000, 8'h00, 0)});
    // slot 7 has counting off: angle stored, turns untouched
    feedback_rows.push_back('{frm(1'b0, 11'd516, 64'hFFFF_0001_0002_0300, 1'b0),
                              1'b1, hit(3'd7, 16'hFFFF, 16'h0001, 16'h0002, 8'h03, 0)});
    feedback_rows.push_back('{frm(1'b0, 11'd516, 64'h0000_FFFF_8000_8000, 1'b0),
                              1'b1, hit(3'd7, 16'h0000, 16'hFFFF, 16'h8000, 8'h80, 0)});
    // jump of exactly the threshold does not count, one more does
    feedback_rows.push_back('{frm(1'b1, 11'd513, 64'h1388_0000_0000_0000, 1'b0),
                              1'b1, hit(3'd0, 16'h1388, 16'h0000, 16'h0000, 8'h00, 0)});
    feedback_rows.push_back('{frm(1'b1, 11'd513, 64'h0000_0000_0000_0000, 1'b0),
                              1'b1, hit(3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 0)});
    feedback_rows.push_back('{frm(1'b1, 11'd513, 64'h1389_0000_0000_0000, 1'b0),
                              1'b1, hit(3'd0, 16'h1389, 16'h0000, 16'h0000, 8'h00, -1)});
    // bus 1 reaches slot 4 too, sharing state with bus 0
    feedback_rows.push_back('{frm(1'b1, 11'd517, 64'h0000_0000_0000_0000, 1'b0),
                              1'b1, hit(3'd4, 16'h0000, 16'h0000, 16'h0000, 8'h00, 0)});
    feedback_rows.push_back('{frm(1'b1, 11'd518, 64'h0123_4567_89AB_CDEF, 1'b0),
                              1'b1, MISS});
    // clear before an accepted frame
    feedback_rows.push_back('{frm(1'b1, 11'd513, 64'h1389_0000_0000_0000, 1'b1),
                              1'b1, hit(3'd0, 16'h1389, 16'h0000, 16'h0000, 8'h00, 0)});
    // clear riding on a rejected frame, then identifier extremes
    feedback_rows.push_back('{frm(1'b0, 11'h7FF, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1),
                              1'b1, MISS});
    feedback_rows.push_back('{frm(1'b1, 11'h000, 64'h5A5A_A5A5_3C3C_C3C3, 1'b0),
                              1'b1, MISS});
    feedback_rows.push_back('{frm(1'b0, 11'd514, 64'h8000_1234_4321_7F00, 1'b0),
                              1'b0, MISS});
    feedback_rows.push_back('{frm(1'b0, 11'd515, 64'h0001_FFFE_0000_00FF, 1'b0),
                              1'b0, MISS});
    feedback_rows.push_back('{frm(1'b1, 11'd514, 64'hEC77_0000_FFFF_0101, 1'b0),
                              1'b0, MISS});
    feedback_rows.push_back('{frm(1'b1, 11'd515, 64'h7FFF_8001_1000_2002, 1'b0),
                              1'b0, MISS});
    feedback_rows.push_back('{frm(1'b1, 11'd516, 64'hFFFF_0000_0000_0000, 1'b0),
                              1'b0, MISS});
    feedback_rows.push_back('{frm(1'b1, 11'd516, 64'h0000_0000_0000_0000, 1'b0),
                              1'b0, MISS});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 54; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 54; end
        default: begin send_pct = 38; recv_pct = 38; end
      endcase

      // Block is drained here, so the registers may change.
      case (phase)
        0: ;
        // window at id 0 over slots 0..7; bus 1 count above eight,
        // only id 2047 maps; every slot counts; any move is a wrap
        1: program_regs(16'd0, 16'd0, 16'd8, 16'd2047, 16'd7, 16'd15,
                        16'd255, 16'd0);
        // bus 0 maps nothing; bus 1 wraps 3..7,0..2; counting off, max threshold
        2: program_regs(16'd2047, 16'd7, 16'd0, 16'd0, 16'd3, 16'd8,
                        16'd0, 16'hFFFF);
        4: program_regs(16'd1000, 16'd5, 16'd9, 16'd1004, 16'd1, 16'd4,
                        16'h00AA, 16'h8000);
        // random settings, upper data bits random too
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom),
                              ($urandom_range(3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(12000)));
      endcase

      if (phase == 0) begin
        foreach (feedback_rows[i])
          send_frame(feedback_rows[i].frame, feedback_rows[i].typed,
                     feedback_rows[i].want);
      end
      repeat (RANDOM_FRAMES) send_frame(random_frame(), 1'b0, MISS);
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    // a few quiet cycles to catch anything the block still pushes out
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
